@@ src/sidta_pkg.sv @@
`default_nettype none
package sidta_pkg;

  localparam int unsigned MagW        = 32;
  localparam int unsigned NumDigits   = 10;
  localparam int unsigned BcdW        = 4 * NumDigits;
  localparam int unsigned NibbleSteps = MagW / 4;
  localparam int unsigned DefaultFifoDepth = 2;

  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharZero  = 8'h30;

  typedef struct packed {
    logic            neg;
    logic [MagW-1:0] mag;
  } sidta_entry_t;

endpackage
`default_nettype wire

@@ src/sidta_front.sv @@
`default_nettype none
module sidta_front
  import sidta_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [MagW-1:0]    value_i,
  output logic                    q_push_o,
  input  wire logic               q_full_i,
  output sidta_entry_t            q_data_o
);

  logic         vld_q, vld_d;
  sidta_entry_t ent_q;
  logic         accept;

  assign full   = vld_q & q_full_i;
  assign accept = push & ~full;
  // stage drains into the queue whenever the queue has room
  assign vld_d  = accept | (vld_q & q_full_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // sign split and magnitude; the most negative value wraps to 2^31 unsigned
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ent_q.neg <= value_i[MagW-1];
      ent_q.mag <= value_i[MagW-1] ? (~value_i + {{(MagW-1){1'b0}}, 1'b1}) : value_i;
    end
  end

  assign q_push_o = vld_q;
  assign q_data_o = ent_q;

endmodule
`default_nettype wire

@@ src/sidta_fifo.sv @@
`default_nettype none
module sidta_fifo
  import sidta_pkg::*;
#(
  parameter int unsigned Depth = DefaultFifoDepth
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  output logic               full_o,
  input  wire sidta_entry_t  data_i,
  input  wire logic          pop_i,
  output logic               empty_o,
  output sidta_entry_t       data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  sidta_entry_t    mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

@@ src/sidta_back.sv @@
`default_nettype none
module sidta_back
  import sidta_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         q_empty_i,
  output logic              q_pop_o,
  input  wire sidta_entry_t q_data_i,
  output logic              empty,
  input  wire logic         pop,
  output logic [7:0]        text_char_o,
  output logic              is_last_o
);

  localparam int unsigned CntW = $clog2(NibbleSteps);
  localparam int unsigned IdxW = $clog2(NumDigits);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_LEAD,
    S_SIGN,
    S_DIGITS
  } state_e;

  state_e          state_q;
  logic [CntW-1:0] cnt_q;
  logic [MagW-1:0] bin_q;
  logic [BcdW-1:0] bcd_q;
  logic            neg_q;
  logic [IdxW-1:0] idx_q, lead_idx;
  logic            out_vld_q, out_last_q;
  logic [7:0]      out_char_q;
  logic            out_free;
  logic            out_load;
  logic [3:0]      cur_digit;
  logic [BcdW-1:0] bcd_next;

  // shift-add-3 over one nibble of the binary magnitude
  function automatic logic [BcdW-1:0] dabble4(input logic [BcdW-1:0] bcd_in,
                                              input logic [3:0] nib);
    logic [BcdW-1:0] b;
    b = bcd_in;
    for (int s = 3; s >= 0; s--) begin
      for (int d = 0; d < NumDigits; d++) begin
        if (b[4*d +: 4] >= 4'd5) begin
          b[4*d +: 4] = b[4*d +: 4] + 4'd3;
        end
      end
      b = {b[BcdW-2:0], nib[s]};
    end
    return b;
  endfunction

  assign bcd_next = dabble4(bcd_q, bin_q[MagW-1 -: 4]);

  // highest nonzero digit, zero gives the units digit
  always_comb begin
    lead_idx = '0;
    for (int d = 1; d < NumDigits; d++) begin
      if (bcd_q[4*d +: 4] != 4'd0) begin
        lead_idx = IdxW'(d);
      end
    end
  end

  assign cur_digit = bcd_q[4*idx_q +: 4];
  assign out_free  = ~out_vld_q | pop;
  assign out_load  = ((state_q == S_SIGN) || (state_q == S_DIGITS)) & out_free;
  assign q_pop_o   = (state_q == S_IDLE) & ~q_empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      bin_q      <= '0;
      bcd_q      <= '0;
      neg_q      <= 1'b0;
      idx_q      <= '0;
      out_vld_q  <= 1'b0;
      out_char_q <= '0;
      out_last_q <= 1'b0;
    end else begin
      out_vld_q <= out_load | (out_vld_q & ~pop);
      unique case (state_q)
        S_IDLE: begin
          if (!q_empty_i) begin
            neg_q   <= q_data_i.neg;
            bin_q   <= q_data_i.mag;
            bcd_q   <= '0;
            cnt_q   <= '0;
            state_q <= S_CONV;
          end
        end
        S_CONV: begin
          bcd_q <= bcd_next;
          bin_q <= {bin_q[MagW-5:0], 4'd0};
          cnt_q <= cnt_q + CntW'(1);
          if (cnt_q == CntW'(NibbleSteps - 1)) begin
            state_q <= S_LEAD;
          end
        end
        S_LEAD: begin
          idx_q   <= lead_idx;
          state_q <= neg_q ? S_SIGN : S_DIGITS;
        end
        S_SIGN: begin
          if (out_free) begin
            out_char_q <= CharMinus;
            out_last_q <= 1'b0;
            state_q    <= S_DIGITS;
          end
        end
        S_DIGITS: begin
          if (out_free) begin
            out_char_q <= CharZero + {4'd0, cur_digit};
            out_last_q <= (idx_q == '0);
            if (idx_q == '0) begin
              state_q <= S_IDLE;
            end else begin
              idx_q <= idx_q - IdxW'(1);
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign empty       = ~out_vld_q;
  assign text_char_o = out_char_q;
  assign is_last_o   = out_last_q;

  a_pop_starts_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> (state_q == S_CONV))
    else $error("queue pop did not start a conversion");

  a_sign_only_negative: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SIGN) |-> neg_q)
    else $error("minus sign for a non-negative value");

  a_digit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIGITS) |-> (cur_digit <= 4'd9))
    else $error("bcd digit out of range");

  a_digit_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DIGITS) && out_free) |=>
      (out_vld_q && (out_char_q >= CharZero) && (out_char_q <= CharZero + 8'd9)))
    else $error("digit beat carries a non-digit character");

endmodule
`default_nettype wire

@@ src/signed_int_to_decimal_ascii.sv @@
// path: input stage register, queue, back end, output register; the input stage and the queue
// take new values while the back end still works on an earlier one
// back end, one value at a time: one queue pop, 8 shift-add-3 nibble steps, one leading-digit
//   search, then one character per cycle into the output register while it is free or popped
// reset: asynchronous, active low; clears the input stage, queue pointers and the back end
`default_nettype none
module signed_int_to_decimal_ascii
  import sidta_pkg::*;
#(
  parameter int unsigned FifoDepth = DefaultFifoDepth
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push,
  output logic                  full,
  input  wire logic [MagW-1:0]  value_i,
  output logic                  empty,
  input  wire logic             pop,
  output logic [7:0]            text_char_o,
  output logic                  is_last_o
);

  logic         q_push, q_full, q_pop, q_empty;
  sidta_entry_t q_wdata, q_rdata;

  sidta_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .value_i  (value_i),
    .q_push_o (q_push),
    .q_full_i (q_full),
    .q_data_o (q_wdata)
  );

  sidta_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .full_o  (q_full),
    .data_i  (q_wdata),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_rdata)
  );

  sidta_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .q_data_i    (q_rdata),
    .empty       (empty),
    .pop         (pop),
    .text_char_o (text_char_o),
    .is_last_o   (is_last_o)
  );

endmodule
`default_nettype wire

@@ dv/tb_signed_int_to_decimal_ascii.sv @@
`timescale 1ns / 1ps
module tb_signed_int_to_decimal_ascii;
  import sidta_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 30;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_beat_t;

  logic            clk_i   = 1'b0;
  logic            rst_ni  = 1'b0;
  logic            push    = 1'b0;
  logic [MagW-1:0] value_i = '0;
  logic            pop     = 1'b0;
  logic            full;
  logic            empty;
  logic [7:0]      text_char_o;
  logic            is_last_o;

  text_beat_t  text_q[$];
  int unsigned errors   = 0;
  int unsigned cycles   = 0;
  int unsigned pop_hold = 0;
  bit          idle_on  = 1'b1;

  signed_int_to_decimal_ascii uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .value_i     (value_i),
    .empty       (empty),
    .pop         (pop),
    .text_char_o (text_char_o),
    .is_last_o   (is_last_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // decimal text of one value, appended to the queue of expected characters
  function automatic void predict_text(input logic [MagW-1:0] val);
    logic [MagW-1:0] mag;
    logic [7:0]      digs[NumDigits];
    int              n;
    // unsigned negation, so the most negative value gives 2147483648
    mag = val[MagW-1] ? (~val + 1'b1) : val;
    n = 0;
    do begin
      digs[n] = CharZero + 8'(mag % 10);
      n++;
      mag = mag / 10;
    end while (mag != 0 && n < NumDigits);
    if (val[MagW-1]) text_q.push_back('{ch: CharMinus, last: 1'b0});
    for (int i = n - 1; i >= 0; i--) begin
      text_q.push_back('{ch: digs[i], last: (i == 0)});
    end
  endfunction

  // mostly values of a random digit count, some raw 32-bit patterns
  function automatic logic [MagW-1:0] random_value();
    longint lo;
    longint hi;
    longint m;
    int     k;
    bit     neg;
    if ($urandom_range(0, 3) == 0) return $urandom;
    k   = $urandom_range(0, NumDigits - 1);
    neg = 1'($urandom_range(0, 1));
    lo  = 1;
    repeat (k) lo = lo * 10;
    hi  = lo * 10 - 1;
    if (k == 0) lo = 0;
    if (hi > 64'd2147483648) hi = 64'd2147483648;
    if (!neg && hi > 64'd2147483647) hi = 64'd2147483647;
    m = lo + longint'($urandom) % (hi - lo + 1);
    return neg ? MagW'(-m) : MagW'(m);
  endfunction

  // push stays high after the beat so the next value can follow at once
  task automatic send_value(input logic [MagW-1:0] val);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    push    <= 1'b1;
    value_i <= val;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_text(val);
  endtask

  always @(posedge clk_i) begin : check_text
    text_beat_t want;
    if (rst_ni && pop && !empty) begin
      if (text_q.size() == 0) begin
        $display("%0t: unexpected beat: expected none, actual char %h last %b",
                 $time, text_char_o, is_last_o);
        errors++;
      end else begin
        want = text_q.pop_front();
        if (text_char_o !== want.ch) begin
          $display("%0t: text_char mismatch: expected %h, actual %h",
                   $time, want.ch, text_char_o);
          errors++;
        end
        if (is_last_o !== want.last) begin
          $display("%0t: is_last mismatch: expected %b, actual %b",
                   $time, want.last, is_last_o);
          errors++;
        end
      end
    end
    // receiver stalls at random in bursts; a new burst starts only while idling is on
    if (pop_hold > 0) begin
      pop_hold--;
      pop <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      pop_hold = $urandom_range(0, 6);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  task automatic test_extremes();
    logic [MagW-1:0] vals[] = '{
      32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10, 32'd99, 32'd100,
      32'd12345, -32'sd6789, 32'd999999999, 32'd1000000000, -32'sd1000000000,
      32'd1999999999, 32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_0000,
      32'h5555_5555, 32'hAAAA_AAAA
    };
    foreach (vals[i]) send_value(vals[i]);
  endtask

  task automatic test_random_values(input int unsigned count);
    repeat (count) send_value(random_value());
  endtask

  // closing stretch with no idling on either side
  task automatic test_streaming(input int unsigned count);
    idle_on = 1'b0;
    repeat (count) send_value(random_value());
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_random_values(180);
    test_streaming(60);
    push <= 1'b0;
    while (text_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ signed_int_to_decimal_ascii.f @@
src/sidta_pkg.sv
src/sidta_front.sv
src/sidta_fifo.sv
src/sidta_back.sv
src/signed_int_to_decimal_ascii.sv
dv/tb_signed_int_to_decimal_ascii.sv
